[hdl/itp_pkg.sv]
// ============================================================================
// itp_pkg
// Shared types, constants and lookup functions of the infix to prefix
// converter: operator codes, priorities, stack sizing and cell control.
// ============================================================================
`default_nettype none

package itp_pkg;

    localparam int STACK_DEPTH = 16;
    localparam int CNT_W       = $clog2(STACK_DEPTH + 1);

    typedef enum logic [2:0] {
        CODE_CLOSE = 3'd0,
        CODE_DOLLAR = 3'd1,
        CODE_CARET = 3'd2,
        CODE_MUL = 3'd3,
        CODE_DIV = 3'd4,
        CODE_MOD = 3'd5,
        CODE_ADD = 3'd6,
        CODE_SUB = 3'd7
    } t_code;

    typedef enum logic [1:0] {
        KIND_OPND  = 2'd0,
        KIND_OP    = 2'd1,
        KIND_OPEN  = 2'd2,
        KIND_CLOSE = 2'd3
    } t_kind;

    typedef enum logic [1:0] {
        ERR_NONE      = 2'd0,
        ERR_OVERFLOW  = 2'd1,
        ERR_UNMATCHED = 2'd2
    } t_err;

    typedef struct packed {
        logic  push;
        logic  pop;
        t_code code;
    } t_cell_ctrl;

    localparam logic [7:0] CH_DOLLAR = 8'h24;
    localparam logic [7:0] CH_CARET  = 8'h5E;
    localparam logic [7:0] CH_MUL    = 8'h2A;
    localparam logic [7:0] CH_DIV    = 8'h2F;
    localparam logic [7:0] CH_MOD    = 8'h25;
    localparam logic [7:0] CH_ADD    = 8'h2B;
    localparam logic [7:0] CH_SUB    = 8'h2D;
    localparam logic [7:0] CH_OPEN   = 8'h28;
    localparam logic [7:0] CH_CLOSE  = 8'h29;

    function automatic logic [7:0] code_char(input t_code code);
        logic [7:0] ch;
        unique case (code)
            CODE_CLOSE:  ch = CH_CLOSE;
            CODE_DOLLAR: ch = CH_DOLLAR;
            CODE_CARET:  ch = CH_CARET;
            CODE_MUL:    ch = CH_MUL;
            CODE_DIV:    ch = CH_DIV;
            CODE_MOD:    ch = CH_MOD;
            CODE_ADD:    ch = CH_ADD;
            CODE_SUB:    ch = CH_SUB;
            default:     ch = CH_CLOSE;
        endcase
        return ch;
    endfunction

    function automatic logic [1:0] code_prio(input t_code code);
        logic [1:0] prio;
        case (code)
            CODE_DOLLAR, CODE_CARET:      prio = 2'd3;
            CODE_MUL, CODE_DIV, CODE_MOD: prio = 2'd2;
            CODE_ADD, CODE_SUB:           prio = 2'd1;
            default:                      prio = 2'd0;
        endcase
        return prio;
    endfunction

    function automatic t_code char_code(input logic [7:0] ch);
        t_code code;
        unique case (ch)
            CH_DOLLAR: code = CODE_DOLLAR;
            CH_CARET:  code = CODE_CARET;
            CH_MUL:    code = CODE_MUL;
            CH_DIV:    code = CODE_DIV;
            CH_MOD:    code = CODE_MOD;
            CH_ADD:    code = CODE_ADD;
            CH_SUB:    code = CODE_SUB;
            default:   code = CODE_CLOSE;
        endcase
        return code;
    endfunction

    function automatic t_kind char_kind(input logic [7:0] ch);
        t_kind kind;
        unique case (ch)
            CH_OPEN:  kind = KIND_OPEN;
            CH_CLOSE: kind = KIND_CLOSE;
            CH_DOLLAR, CH_CARET, CH_MUL, CH_DIV, CH_MOD, CH_ADD, CH_SUB:
                kind = KIND_OP;
            default:  kind = KIND_OPND;
        endcase
        return kind;
    endfunction

endpackage

`default_nettype wire

[hdl/itp_stack_cell.sv]
// ============================================================================
// itp_stack_cell
// One entry of the shifting operator stack. A push takes the code of the
// neighbor above, a pop takes the code of the neighbor below.
// ============================================================================
`default_nettype none

module itp_stack_cell
    import itp_pkg::*;
(
    input  wire        i_clk,
    input  wire t_cell_ctrl i_ctrl,
    input  wire t_code      i_from_above,
    input  wire t_code      i_from_below,
    output t_code      o_code
);

    t_code r_code;

    always_ff @(posedge i_clk) begin
        if (i_ctrl.push) begin
            r_code <= i_from_above;
        end else if (i_ctrl.pop) begin
            r_code <= i_from_below;
        end
    end

    assign o_code = r_code;

endmodule

`default_nettype wire

[hdl/infix_to_prefix_converter.sv]
// ============================================================================
// infix_to_prefix_converter
// Operator-stack infix to prefix converter fed right to left; emits the
// prefix expression in reverse order.
// ============================================================================
// Characters enter one per transaction, rightmost first, with tlast on the
// leftmost one, and a new character is taken only once the last one is
// through. Each operator popped by an operator or by '(', and each entry
// popped by the flush after the leftmost character, takes a step of its own,
// since the stack is a chain of shift cells that moves one entry per cycle
// unless a result waits on a stalled output register; a held result and the
// final result of a character that both wait for the single output register
// go out one after the other. The stack needs no clearing after reset.
`default_nettype none

module infix_to_prefix_converter
    import itp_pkg::*;
(
    input  wire        i_clk,
    input  wire        i_rst_n,
    input  wire        s_axis_tvalid,
    output logic       s_axis_tready,
    input  wire  [7:0] s_axis_tdata,   // [7:0] char_in
    input  wire        s_axis_tlast,   // is_leftmost
    output logic       m_axis_tvalid,
    input  wire        m_axis_tready,
    output logic [7:0] m_axis_tdata,   // [7:0] char_out
    output logic       m_axis_tlast,   // run_last
    output logic [2:0] m_axis_tuser    // [0] expr_done, [2:1] error_code
);

    typedef enum logic [3:0] {
        ST_IDLE   = 4'b0001,
        ST_WORK   = 4'b0010,
        ST_FLUSH  = 4'b0100,
        ST_FINISH = 4'b1000
    } t_state;

    t_state           r_state, n_state;
    logic [7:0]       r_ch;
    logic             r_last;
    t_kind            r_kind;
    t_code            r_code;
    logic [CNT_W-1:0] r_cnt, n_cnt;

    logic             r_hold_valid, n_hold_valid;
    logic [7:0]       r_hold_char, n_hold_char;
    t_err             r_hold_err, n_hold_err;

    logic             r_out_valid, n_out_valid;
    logic [7:0]       r_out_char, n_out_char;
    t_err             r_out_err, n_out_err;
    logic             r_out_run_last, n_out_run_last;
    logic             r_out_expr_done, n_out_expr_done;

    t_code            w_cell_code [STACK_DEPTH];
    t_cell_ctrl       w_ctrl;
    t_code            w_top;
    logic             w_empty, w_full, w_out_free, w_accept;
    logic             w_gen, w_do_push, w_do_pop, w_phase_end, w_fin, w_go, w_need_move;
    logic [7:0]       w_gen_char;
    t_err             w_gen_err;
    logic [CNT_W-1:0] w_cnt_step;

    assign w_top      = w_cell_code[0];
    assign w_empty    = (r_cnt == '0);
    assign w_full     = (r_cnt == CNT_W'(STACK_DEPTH));
    assign w_out_free = !r_out_valid || m_axis_tready;
    assign w_accept   = s_axis_tvalid && s_axis_tready;

    assign s_axis_tready = (r_state == ST_IDLE);

    always_comb begin
        w_gen       = 1'b0;
        w_gen_char  = 8'h00;
        w_gen_err   = ERR_NONE;
        w_do_push   = 1'b0;
        w_do_pop    = 1'b0;
        w_phase_end = 1'b0;
        w_fin       = 1'b0;
        w_ctrl.code = r_code;
        unique case (r_state)
            ST_WORK: begin
                case (r_kind)
                    KIND_CLOSE: begin
                        w_ctrl.code = CODE_CLOSE;
                        w_phase_end = 1'b1;
                        if (w_full) begin
                            w_gen     = 1'b1;
                            w_gen_err = ERR_OVERFLOW;
                        end else begin
                            w_do_push = 1'b1;
                        end
                    end
                    KIND_OPEN: begin
                        if (w_empty) begin
                            w_gen       = 1'b1;
                            w_gen_err   = ERR_UNMATCHED;
                            w_phase_end = 1'b1;
                        end else begin
                            w_do_pop = 1'b1;
                            if (w_top == CODE_CLOSE) begin
                                w_phase_end = 1'b1;
                            end else begin
                                w_gen      = 1'b1;
                                w_gen_char = code_char(w_top);
                            end
                        end
                    end
                    KIND_OP: begin
                        if (!w_empty && (code_prio(w_top) > code_prio(r_code))) begin
                            w_do_pop   = 1'b1;
                            w_gen      = 1'b1;
                            w_gen_char = code_char(w_top);
                        end else begin
                            w_phase_end = 1'b1;
                            if (w_full) begin
                                w_gen     = 1'b1;
                                w_gen_err = ERR_OVERFLOW;
                            end else begin
                                w_do_push = 1'b1;
                            end
                        end
                    end
                    default: begin
                        w_gen       = 1'b1;
                        w_gen_char  = r_ch;
                        w_phase_end = 1'b1;
                    end
                endcase
            end
            ST_FLUSH: begin
                if (w_empty) begin
                    w_fin = 1'b1;
                end else begin
                    w_do_pop = 1'b1;
                    w_gen    = 1'b1;
                    w_fin    = (r_cnt == CNT_W'(1));
                    if (w_top == CODE_CLOSE) begin
                        w_gen_err = ERR_UNMATCHED;
                    end else begin
                        w_gen_char = code_char(w_top);
                    end
                end
            end
            default: begin
            end
        endcase

        w_cnt_step = r_cnt + CNT_W'(w_do_push) - CNT_W'(w_do_pop);
        if (r_state == ST_WORK) begin
            w_fin = w_phase_end && (!r_last || (w_cnt_step == '0));
        end

        if (r_state == ST_FINISH) begin
            w_need_move = 1'b1;
        end else if (w_fin) begin
            w_need_move = w_gen || r_hold_valid || r_last;
        end else begin
            w_need_move = w_gen && r_hold_valid;
        end
        w_go = !w_need_move || w_out_free;

        w_ctrl.push = w_do_push && w_go;
        w_ctrl.pop  = w_do_pop && w_go;
    end

    always_comb begin
        n_state         = r_state;
        n_cnt           = r_cnt;
        n_hold_valid    = r_hold_valid;
        n_hold_char     = r_hold_char;
        n_hold_err      = r_hold_err;
        n_out_valid     = r_out_valid && !m_axis_tready;
        n_out_char      = r_out_char;
        n_out_err       = r_out_err;
        n_out_run_last  = r_out_run_last;
        n_out_expr_done = r_out_expr_done;

        unique case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    n_state = ST_WORK;
                end
            end
            ST_WORK, ST_FLUSH: begin
                if (w_go) begin
                    n_cnt = w_cnt_step;
                    if (w_fin) begin
                        n_state = ST_IDLE;
                        if (w_gen && r_hold_valid) begin
                            n_out_valid     = 1'b1;
                            n_out_char      = r_hold_char;
                            n_out_err       = r_hold_err;
                            n_out_run_last  = 1'b0;
                            n_out_expr_done = 1'b0;
                            n_hold_char     = w_gen_char;
                            n_hold_err      = w_gen_err;
                            n_state         = ST_FINISH;
                        end else if (w_gen) begin
                            n_out_valid     = 1'b1;
                            n_out_char      = w_gen_char;
                            n_out_err       = w_gen_err;
                            n_out_run_last  = 1'b1;
                            n_out_expr_done = r_last;
                        end else if (r_hold_valid) begin
                            n_hold_valid    = 1'b0;
                            n_out_valid     = 1'b1;
                            n_out_char      = r_hold_char;
                            n_out_err       = r_hold_err;
                            n_out_run_last  = 1'b1;
                            n_out_expr_done = r_last;
                        end else if (r_last) begin
                            n_out_valid     = 1'b1;
                            n_out_char      = 8'h00;
                            n_out_err       = ERR_NONE;
                            n_out_run_last  = 1'b1;
                            n_out_expr_done = 1'b1;
                        end
                    end else begin
                        if (w_phase_end) begin
                            n_state = ST_FLUSH;
                        end
                        if (w_gen) begin
                            if (r_hold_valid) begin
                                n_out_valid     = 1'b1;
                                n_out_char      = r_hold_char;
                                n_out_err       = r_hold_err;
                                n_out_run_last  = 1'b0;
                                n_out_expr_done = 1'b0;
                            end
                            n_hold_valid = 1'b1;
                            n_hold_char  = w_gen_char;
                            n_hold_err   = w_gen_err;
                        end
                    end
                end
            end
            ST_FINISH: begin
                if (w_go) begin
                    n_state         = ST_IDLE;
                    n_hold_valid    = 1'b0;
                    n_out_valid     = 1'b1;
                    n_out_char      = r_hold_char;
                    n_out_err       = r_hold_err;
                    n_out_run_last  = 1'b1;
                    n_out_expr_done = r_last;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_cnt        <= '0;
            r_hold_valid <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_cnt        <= n_cnt;
            r_hold_valid <= n_hold_valid;
            r_out_valid  <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_ch   <= s_axis_tdata;
            r_last <= s_axis_tlast;
            r_kind <= char_kind(s_axis_tdata);
            r_code <= char_code(s_axis_tdata);
        end
        r_hold_char     <= n_hold_char;
        r_hold_err      <= n_hold_err;
        r_out_char      <= n_out_char;
        r_out_err       <= n_out_err;
        r_out_run_last  <= n_out_run_last;
        r_out_expr_done <= n_out_expr_done;
    end

    genvar g_i;
    generate
        for (g_i = 0; g_i < STACK_DEPTH; g_i++) begin : g_cell
            t_code w_above;
            t_code w_below;
            if (g_i == 0) begin : g_top
                assign w_above = w_ctrl.code;
            end else begin : g_mid
                assign w_above = w_cell_code[g_i-1];
            end
            if (g_i == STACK_DEPTH - 1) begin : g_bottom
                assign w_below = CODE_CLOSE;
            end else begin : g_inner
                assign w_below = w_cell_code[g_i+1];
            end
            itp_stack_cell u_cell (
                .i_clk        (i_clk),
                .i_ctrl       (w_ctrl),
                .i_from_above (w_above),
                .i_from_below (w_below),
                .o_code       (w_cell_code[g_i])
            );
        end
    endgenerate

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_char;
    assign m_axis_tlast  = r_out_run_last;
    assign m_axis_tuser  = {r_out_err, r_out_expr_done};

    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CNT_W'(STACK_DEPTH))
        else $error("Stack count exceeds the stack depth.");

    a_idle_no_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_IDLE) |-> !r_hold_valid)
        else $error("A result is still held while waiting for a new character.");

    a_done_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tuser[0]) |-> m_axis_tlast)
        else $error("Expression end without end of character run.");

    a_flush_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_go && w_fin && r_last && (r_state != ST_IDLE)) |=> (r_cnt == '0))
        else $error("Stack not empty after the leftmost character.");

    a_err_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && (m_axis_tuser[2:1] != ERR_NONE)) |-> (m_axis_tdata == 8'h00))
        else $error("Error transaction carries a nonzero character.");

endmodule

`default_nettype wire
